### src/u8w_pkg.sv
// ----------------------------------------------------------------------------
// u8w_pkg
// Shared types and constants for the streaming UTF-8 decoder with display
// width: result entry layout, byte range limits and combining mark ranges.
// ----------------------------------------------------------------------------
`default_nettype none

package u8w_pkg;

   // field widths of one result word and the result list bounds
   localparam int CP_W        = 21;
   localparam int BC_W        = 3;
   localparam int COLS_W      = 16;
   localparam int MAX_RESULTS = 5;
   localparam int CNT_W       = 3;

   // byte classes
   localparam logic [7:0] BYTE_NUL      = 8'h00;
   localparam logic [7:0] BYTE_NEWLINE  = 8'h0A;
   localparam logic [7:0] BYTE_ASCII_HI = 8'h7F;
   localparam logic [7:0] CONT_LO       = 8'h80;
   localparam logic [7:0] CONT_HI       = 8'hBF;
   localparam logic [7:0] LEAD2_LO      = 8'hC2;
   localparam logic [7:0] LEAD2_HI      = 8'hDF;
   localparam logic [7:0] LEAD3_LO      = 8'hE0;
   localparam logic [7:0] LEAD3_HI      = 8'hEF;
   localparam logic [7:0] LEAD4_LO      = 8'hF0;
   localparam logic [7:0] LEAD4_HI      = 8'hF4;

   // leads with a narrowed second byte
   localparam logic [7:0] LEAD_E0 = 8'hE0;
   localparam logic [7:0] LEAD_ED = 8'hED;
   localparam logic [7:0] LEAD_F0 = 8'hF0;
   localparam logic [7:0] LEAD_F4 = 8'hF4;
   localparam logic [7:0] E0_LO   = 8'hA0;
   localparam logic [7:0] ED_HI   = 8'h9F;
   localparam logic [7:0] F0_LO   = 8'h90;
   localparam logic [7:0] F4_HI   = 8'h8F;

   // sequence lengths
   localparam logic [2:0] LEN_NONE = 3'd0;
   localparam logic [2:0] LEN_ONE  = 3'd1;
   localparam logic [2:0] LEN_TWO  = 3'd2;
   localparam logic [2:0] LEN_THREE = 3'd3;
   localparam logic [2:0] LEN_FOUR = 3'd4;

   // combining mark ranges
   localparam logic [CP_W-1:0] COMB0_LO = 21'h000300;
   localparam logic [CP_W-1:0] COMB0_HI = 21'h00036F;
   localparam logic [CP_W-1:0] COMB1_LO = 21'h001AB0;
   localparam logic [CP_W-1:0] COMB1_HI = 21'h001AFF;
   localparam logic [CP_W-1:0] COMB2_LO = 21'h001DC0;
   localparam logic [CP_W-1:0] COMB2_HI = 21'h001DFF;
   localparam logic [CP_W-1:0] COMB3_LO = 21'h0020D0;
   localparam logic [CP_W-1:0] COMB3_HI = 21'h0020FF;
   localparam logic [CP_W-1:0] COMB4_LO = 21'h00FE20;
   localparam logic [CP_W-1:0] COMB4_HI = 21'h00FE2F;

   typedef enum logic [0:0] {
      KIND_CODE_POINT = 1'b0,
      KIND_SUMMARY    = 1'b1
   } kind_type;

   // one pending result, before width bookkeeping
   typedef struct packed {
      kind_type          kind;
      logic [CP_W-1:0]   cp;
      logic [BC_W-1:0]   bc;
   } entry_type;

   // all results caused by one input word
   typedef struct packed {
      entry_type [MAX_RESULTS-1:0] ent;
      logic [CNT_W-1:0]            count;
   } list_type;

   function automatic logic is_combining(input logic [CP_W-1:0] cp);
      return (cp >= COMB0_LO && cp <= COMB0_HI) || (cp >= COMB1_LO && cp <= COMB1_HI)
          || (cp >= COMB2_LO && cp <= COMB2_HI) || (cp >= COMB3_LO && cp <= COMB3_HI)
          || (cp >= COMB4_LO && cp <= COMB4_HI);
   endfunction

   function automatic entry_type raw_entry(input logic [7:0] b);
      entry_type e;
      e.kind = KIND_CODE_POINT;
      e.cp   = CP_W'(b);
      e.bc   = LEN_ONE;
      return e;
   endfunction

endpackage

`default_nettype wire

### src/u8w_req_if.sv
// ----------------------------------------------------------------------------
// u8w_req_if
// Input channel: one string byte per word with an end marker.
// ----------------------------------------------------------------------------
`default_nettype none

interface u8w_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_string;

   modport source (output valid, output data_byte, output end_of_string, input ready);
   modport sink   (input valid, input data_byte, input end_of_string, output ready);
endinterface

`default_nettype wire

### src/u8w_rsp_if.sv
// ----------------------------------------------------------------------------
// u8w_rsp_if
// Result channel: one decoded code point or end-of-string summary per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface u8w_rsp_if;
   import u8w_pkg::*;

   logic              valid;
   logic              ready;
   logic              result_kind;
   logic [CP_W-1:0]   code_point;
   logic [BC_W-1:0]   byte_count;
   logic              is_combining;
   logic [COLS_W-1:0] columns_so_far;
   logic              final_result;

   modport source (output valid, output result_kind, output code_point, output byte_count,
                   output is_combining, output columns_so_far, output final_result,
                   input ready);
   modport sink   (input valid, input result_kind, input code_point, input byte_count,
                   input is_combining, input columns_so_far, input final_result,
                   output ready);
endinterface

`default_nettype wire

### src/utf8_stream_decoder_width_unit.sv
// path: an accepted word is loaded whole into the result list, and its first
//   result is registered from there into the output register
// throughput: one byte per cycle while each byte gives at most one result and
//   the output is not stalled; a byte giving several results (up to five) holds
//   the input while the list drains one word per unstalled cycle to the output
// reset: clears the open sequence, width count, result list and output valid
// ----------------------------------------------------------------------------
// utf8_stream_decoder_width_unit
// Strict streaming UTF-8 decoder that reports each code point with a running
// display width and closes every string with a summary word.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_stream_decoder_width_unit #(
   parameter int WIDTH_BITS = 16
) (
   input wire logic clock,
   input wire logic reset,
   u8w_req_if.sink  req_ch,
   u8w_rsp_if.source rsp_ch
);
   import u8w_pkg::*;

   list_type                    list;
   logic                        req_fire;
   logic                        out_load;
   logic                        pop;

   entry_type [MAX_RESULTS-1:0] seq_ff;
   entry_type [MAX_RESULTS-1:0] seq_in;
   logic [CNT_W-1:0]            cnt_ff;
   logic [CNT_W-1:0]            cnt_in;
   logic [WIDTH_BITS-1:0]       width_ff;
   logic [WIDTH_BITS-1:0]       width_in;
   logic [WIDTH_BITS-1:0]       width_next;

   logic              rsp_valid_ff;
   logic              kind_ff;
   logic [CP_W-1:0]   cp_ff;
   logic [BC_W-1:0]   bc_ff;
   logic              comb_ff;
   logic [COLS_W-1:0] cols_ff;
   logic              final_ff;
   logic              comb_now;
   logic [COLS_W-1:0] cols_now;

   // handshake
   assign out_load     = !rsp_valid_ff || rsp_ch.ready;
   assign pop          = (cnt_ff != '0) && out_load;
   assign req_ch.ready = (cnt_ff == '0) || ((cnt_ff == CNT_W'(1)) && out_load);
   assign req_fire     = req_ch.valid && req_ch.ready;

   // sequence tracking and result expansion
   u8w_seq_decode u_decode (
      .clock         (clock),
      .reset         (reset),
      .fire          (req_fire),
      .data_byte     (req_ch.data_byte),
      .end_of_string (req_ch.end_of_string),
      .list          (list)
   );

   // result list: loaded whole, drained from the front
   always_comb begin
      seq_in = seq_ff;
      cnt_in = cnt_ff;
      if (req_fire) begin
         seq_in = list.ent;
         cnt_in = list.count;
      end else if (pop) begin
         for (int i = 0; i < MAX_RESULTS - 1; i++) begin
            seq_in[i] = seq_ff[i+1];
         end
         cnt_in = cnt_ff - 1'b1;
      end
   end

   // display width of the head word, saturating
   always_comb begin
      comb_now   = is_combining(seq_ff[0].cp);
      width_next = width_ff;
      if (seq_ff[0].cp != CP_W'(BYTE_NEWLINE) && !comb_now && width_ff != '1) begin
         width_next = width_ff + 1'b1;
      end
      width_in = width_ff;
      cols_now = COLS_W'(width_ff);
      if (pop) begin
         if (seq_ff[0].kind == KIND_SUMMARY) begin
            width_in = '0;
         end else begin
            width_in = width_next;
            cols_now = COLS_W'(width_next);
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         width_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff   <= cnt_in;
         width_ff <= width_in;
         if (out_load) begin
            rsp_valid_ff <= pop;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      seq_ff <= seq_in;
      if (pop) begin
         kind_ff  <= seq_ff[0].kind;
         cp_ff    <= seq_ff[0].cp;
         bc_ff    <= seq_ff[0].bc;
         comb_ff  <= (seq_ff[0].kind == KIND_CODE_POINT) && comb_now;
         cols_ff  <= cols_now;
         final_ff <= (cnt_ff == CNT_W'(1));
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.result_kind    = kind_ff;
   assign rsp_ch.code_point     = cp_ff;
   assign rsp_ch.byte_count     = bc_ff;
   assign rsp_ch.is_combining   = comb_ff;
   assign rsp_ch.columns_so_far = cols_ff;
   assign rsp_ch.final_result   = final_ff;

   // checks
   a_list_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_RESULTS))
      else $error("result list over capacity");

   a_summary_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && kind_ff == KIND_SUMMARY |-> final_ff)
      else $error("summary word not marked final");

   a_width_cleared: assert property (@(posedge clock) disable iff (reset)
      pop && seq_ff[0].kind == KIND_SUMMARY |=> width_ff == '0)
      else $error("width not cleared after summary");

   a_code_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && kind_ff == KIND_CODE_POINT |->
         (bc_ff == LEN_ONE || bc_ff == LEN_TWO || bc_ff == LEN_THREE || bc_ff == LEN_FOUR))
      else $error("decoded word with bad byte count");

   a_load_empty: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> cnt_ff == $past(list.count))
      else $error("result list lost words on load");

endmodule

`default_nettype wire

### src/u8w_seq_decode.sv
// ----------------------------------------------------------------------------
// u8w_seq_decode
// Holds the open UTF-8 sequence and expands each accepted byte into the
// ordered list of results it causes (raw flushes, decoded point, summary).
// ----------------------------------------------------------------------------
`default_nettype none

module u8w_seq_decode (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             fire,
   input  wire logic [7:0]       data_byte,
   input  wire logic             end_of_string,
   output u8w_pkg::list_type     list
);
   import u8w_pkg::*;

   logic [7:0] pend_ff [3];
   logic [1:0] pcount_ff;
   logic [2:0] explen_ff;

   logic [7:0]      pend_in [3];
   logic [1:0]      pcnt_n;
   logic [2:0]      len_n;
   logic            open_seq;
   logic [7:0]      lo;
   logic [7:0]      hi;
   logic            fits;
   logic            take;
   logic            complete;
   logic            lead;
   logic [2:0]      new_len;
   logic            ends;
   logic            flush_all;
   logic [CP_W-1:0] cp;
   entry_type [7:0] slot;
   logic [7:0]      slot_v;
   logic [CNT_W-1:0] n;

   // continuation range check, narrowed on the second byte
   always_comb begin
      lo = CONT_LO;
      hi = CONT_HI;
      if (pcount_ff == 2'd1) begin
         unique case (pend_ff[0])
            LEAD_E0: lo = E0_LO;
            LEAD_ED: hi = ED_HI;
            LEAD_F0: lo = F0_LO;
            LEAD_F4: hi = F4_HI;
            default: ;
         endcase
      end
      open_seq = (pcount_ff != 2'd0);
      fits     = (data_byte >= lo) && (data_byte <= hi);
      take     = open_seq && fits;
      complete = take && (({1'b0, pcount_ff} + 3'd1) >= explen_ff);
   end

   // code point assembly
   always_comb begin
      unique case (explen_ff)
         LEN_TWO:
            cp = CP_W'({pend_ff[0][4:0], data_byte[5:0]});
         LEN_THREE:
            cp = CP_W'({pend_ff[0][3:0], pend_ff[1][5:0], data_byte[5:0]});
         default:
            cp = {pend_ff[0][2:0], pend_ff[1][5:0], pend_ff[2][5:0], data_byte[5:0]};
      endcase
   end

   // lead classification and next sequence state
   always_comb begin
      new_len = LEN_NONE;
      if (data_byte >= LEAD2_LO && data_byte <= LEAD2_HI) begin
         new_len = LEN_TWO;
      end else if (data_byte >= LEAD3_LO && data_byte <= LEAD3_HI) begin
         new_len = LEN_THREE;
      end else if (data_byte >= LEAD4_LO && data_byte <= LEAD4_HI) begin
         new_len = LEN_FOUR;
      end
      lead = (new_len != LEN_NONE);

      pend_in = pend_ff;
      pcnt_n  = pcount_ff;
      len_n   = explen_ff;
      if (take) begin
         if (complete) begin
            pcnt_n = 2'd0;
            len_n  = LEN_NONE;
         end else begin
            pend_in[pcount_ff] = data_byte;
            pcnt_n = pcount_ff + 2'd1;
         end
      end else begin
         pcnt_n = 2'd0;
         len_n  = LEN_NONE;
         if (lead) begin
            pend_in[0] = data_byte;
            pcnt_n = 2'd1;
            len_n  = new_len;
         end
      end
      ends      = !take && (data_byte == BYTE_NUL);
      flush_all = ends || end_of_string;
   end

   // candidate results in emission order, then packed to the front
   always_comb begin
      slot   = '0;
      slot_v = '0;
      for (int i = 0; i < 3; i++) begin
         slot[i]   = raw_entry(pend_ff[i]);
         slot_v[i] = open_seq && !fits && (2'(i) < pcount_ff);
      end
      if (complete) begin
         slot[3].kind = KIND_CODE_POINT;
         slot[3].cp   = cp;
         slot[3].bc   = explen_ff;
         slot_v[3]    = 1'b1;
      end else if (!take && data_byte != BYTE_NUL && !lead) begin
         slot[3]   = raw_entry(data_byte);
         slot_v[3] = 1'b1;
      end
      for (int i = 0; i < 3; i++) begin
         slot[4+i]   = raw_entry(pend_in[i]);
         slot_v[4+i] = flush_all && (2'(i) < pcnt_n);
      end
      slot[7].kind = KIND_SUMMARY;
      slot[7].cp   = '0;
      slot[7].bc   = '0;
      slot_v[7]    = flush_all;

      list = '0;
      n    = '0;
      for (int k = 0; k < 8; k++) begin
         if (slot_v[k] && n < CNT_W'(MAX_RESULTS)) begin
            list.ent[n] = slot[k];
            n = n + 1'b1;
         end
      end
      list.count = n;
   end

   // sequence state
   always_ff @(posedge clock) begin
      if (reset) begin
         pcount_ff <= 2'd0;
         explen_ff <= LEN_NONE;
      end else if (fire) begin
         pcount_ff <= flush_all ? 2'd0 : pcnt_n;
         explen_ff <= flush_all ? LEN_NONE : len_n;
      end
   end

   // held bytes of the open sequence
   always_ff @(posedge clock) begin
      if (fire) begin
         pend_ff <= pend_in;
      end
   end

endmodule

`default_nettype wire
